[hdl/qla_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qla_pkg
// Shared types and codes for the queued lock arbiter.
// ----------------------------------------------------------------------------
package qla_pkg;

  typedef enum logic [1:0] {
    CMD_LOCK   = 2'd0,
    CMD_EDIT   = 2'd1,
    CMD_UNLOCK = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    RSP_LOCK_OK   = 3'd0,
    RSP_ALREADY   = 3'd1,
    RSP_WAIT      = 3'd2,
    RSP_EDIT_OK   = 3'd3,
    RSP_NO_LOCK   = 3'd4,
    RSP_UNLOCKED  = 3'd5,
    RSP_FULL      = 3'd6
  } rsp_t;

  localparam int ADDR_W = 32;
  localparam int PORT_W = 16;
  localparam int TICKS_W = 16;
  localparam logic [TICKS_W-1:0] TIMEOUT_RESET = 16'd60;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } item_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    item_t head;
  } cmdq_status_t;

endpackage

[hdl/qla_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qla_front
// Input stage: registers an accepted beat, decodes it and pushes it on.
// ----------------------------------------------------------------------------
module qla_front import qla_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [ADDR_W-1:0]     in_client_addr,
  input  logic [PORT_W-1:0]     in_client_port,
  input  logic                  q_full,
  output logic                  push,
  output item_t                 push_item
);

  logic  fe_valid_r;
  item_t fe_item_r;
  logic  accept;

  assign in_stall  = fe_valid_r && q_full;
  assign accept    = in_valid && !in_stall;
  assign push      = fe_valid_r && !q_full;
  assign push_item = fe_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fe_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fe_valid_r     <= 1'b1;
        fe_item_r.cmd  <= cmd_t'(in_command);
        // tick carries no client
        if (cmd_t'(in_command) == CMD_TICK) begin
          fe_item_r.addr <= '0;
          fe_item_r.port <= '0;
        end else begin
          fe_item_r.addr <= in_client_addr;
          fe_item_r.port <= in_client_port;
        end
      end else if (push) begin
        fe_valid_r <= 1'b0;
      end
    end
  end

endmodule

[hdl/qla_cmdq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qla_cmdq
// Two-entry command queue between the front stage and the engine.
// ----------------------------------------------------------------------------
module qla_cmdq import qla_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  item_t        push_item,
  input  logic         pop,
  output cmdq_status_t status
);

  item_t       slot_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;

  assign status.empty = (count_r == 2'd0);
  assign status.full  = (count_r == 2'd2);
  assign status.head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule

[hdl/qla_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qla_engine
// Lock state, waiter FIFO and reply sequencer with output register.
// ----------------------------------------------------------------------------
module qla_engine import qla_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  input  logic [TICKS_W-1:0]  cfg_timeout_ticks,
  input  cmdq_status_t        q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   out_reply_addr,
  output logic [PORT_W-1:0]   out_dest_port,
  output logic [2:0]          out_response,
  output logic                out_last
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GRANT,
    ST_REPLY
  } state_t;

  state_t                      state_r;
  logic [TICKS_W-1:0]          timeout_r;
  logic                        held_r;
  logic [ADDR_W-1:0]           holder_addr_r;
  logic [PORT_W-1:0]           holder_port_r;
  logic [TICKS_W-1:0]          timer_r;
  logic [PTR_W-1:0]            head_r;
  logic [PTR_W-1:0]            tail_r;
  logic [CNT_W-1:0]            count_r;
  logic                        unlock_r;
  logic [ADDR_W-1:0]           req_addr_r;
  logic [PORT_W-1:0]           req_port_r;
  logic [ADDR_W+PORT_W-1:0]    mem [QUEUE_DEPTH];
  logic [ADDR_W+PORT_W-1:0]    rd_data_r;

  logic                        out_valid_r;
  logic [ADDR_W-1:0]           out_addr_r;
  logic [PORT_W-1:0]           out_port_r;
  rsp_t                        out_rsp_r;
  logic                        out_last_r;

  item_t                       cur;
  logic                        out_free;
  logic                        out_load;
  logic                        is_holder;
  logic                        q_not_full;
  logic                        enq;

  assign cur        = q_status.head;
  assign out_free   = !out_valid_r || !out_stall;
  assign pop        = (state_r == ST_IDLE) && !q_status.empty && out_free;
  assign is_holder  = held_r && (holder_addr_r == cur.addr) && (holder_port_r == cur.port);
  assign q_not_full = (count_r < DEPTH_CNT);
  assign enq        = pop && (cur.cmd == CMD_LOCK) && held_r && !is_holder && q_not_full;
  // a beat loads on each pop but ticks and unlocks with waiters, and in grant/reply
  assign out_load   = (pop && (cur.cmd != CMD_TICK) &&
                       !((cur.cmd == CMD_UNLOCK) && (count_r != '0))) ||
                      ((state_r != ST_IDLE) && out_free);

  assign out_valid      = out_valid_r;
  assign out_reply_addr = out_addr_r;
  assign out_dest_port  = out_port_r;
  assign out_response   = out_rsp_r;
  assign out_last       = out_last_r;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (enq) begin
      mem[tail_r] <= {cur.addr, cur.port};
    end
    rd_data_r <= mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      timeout_r     <= TIMEOUT_RESET;
      held_r        <= 1'b0;
      holder_addr_r <= '0;
      holder_port_r <= '0;
      timer_r       <= '0;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      unlock_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        timeout_r <= cfg_timeout_ticks;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            req_addr_r <= cur.addr;
            req_port_r <= cur.port;
            unique case (cur.cmd)
              CMD_LOCK: begin
                out_addr_r  <= cur.addr;
                out_port_r  <= cur.port;
                out_last_r  <= 1'b1;
                if (!held_r) begin
                  held_r        <= 1'b1;
                  holder_addr_r <= cur.addr;
                  holder_port_r <= cur.port;
                  timer_r       <= timeout_r;
                  out_rsp_r     <= RSP_LOCK_OK;
                end else if (is_holder) begin
                  out_rsp_r <= RSP_ALREADY;
                end else if (q_not_full) begin
                  tail_r    <= next_slot(tail_r);
                  count_r   <= count_r + CNT_W'(1);
                  out_rsp_r <= RSP_WAIT;
                end else begin
                  out_rsp_r <= RSP_FULL;
                end
              end
              CMD_EDIT: begin
                out_addr_r  <= cur.addr;
                out_port_r  <= cur.port;
                out_last_r  <= 1'b1;
                if (is_holder) begin
                  timer_r   <= timeout_r;
                  out_rsp_r <= RSP_EDIT_OK;
                end else begin
                  out_rsp_r <= RSP_NO_LOCK;
                end
              end
              CMD_UNLOCK: begin
                held_r <= 1'b0;
                if (count_r == '0) begin
                  out_addr_r  <= cur.addr;
                  out_port_r  <= cur.port;
                  out_rsp_r   <= RSP_UNLOCKED;
                  out_last_r  <= 1'b1;
                end else begin
                  unlock_r <= 1'b1;
                  state_r  <= ST_GRANT;
                end
              end
              CMD_TICK: begin
                if (held_r) begin
                  if (timer_r <= TICKS_W'(1)) begin
                    timer_r <= '0;
                    held_r  <= 1'b0;
                    if (count_r != '0) begin
                      unlock_r <= 1'b0;
                      state_r  <= ST_GRANT;
                    end
                  end else begin
                    timer_r <= timer_r - TICKS_W'(1);
                  end
                end
              end
              default: ;
            endcase
          end
        end
        ST_GRANT: begin
          if (out_free) begin
            held_r        <= 1'b1;
            holder_addr_r <= rd_data_r[ADDR_W+PORT_W-1:PORT_W];
            holder_port_r <= rd_data_r[PORT_W-1:0];
            timer_r       <= timeout_r;
            head_r        <= next_slot(head_r);
            count_r       <= count_r - CNT_W'(1);
            out_addr_r    <= rd_data_r[ADDR_W+PORT_W-1:PORT_W];
            out_port_r    <= rd_data_r[PORT_W-1:0];
            out_rsp_r     <= RSP_LOCK_OK;
            out_last_r    <= !unlock_r;
            state_r       <= unlock_r ? ST_REPLY : ST_IDLE;
          end
        end
        ST_REPLY: begin
          if (out_free) begin
            out_addr_r  <= req_addr_r;
            out_port_r  <= req_port_r;
            out_rsp_r   <= RSP_UNLOCKED;
            out_last_r  <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_CNT)
    else $error("waiter count exceeds depth");

  a_grant_has_waiter: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRANT) |-> (count_r != '0) && !held_r)
    else $error("grant step without waiter or with lock held");

  a_reply_after_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REPLY) |-> held_r && out_valid_r)
    else $error("unlock reply without new holder");

  a_enq_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    enq |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("enqueue did not advance count");
`endif

endmodule

[hdl/queued_lock_arbiter_with_timeout.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queued_lock_arbiter_with_timeout
// Exclusive lock with a FIFO of waiters and an inactivity timeout.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (in_*) carry a command and a client; result beats (out_*)
//   carry a reply to a client, with out_last on the final reply of a command.
//   A tick gives a reply only when it hands the lock on to a waiter.
//   cfg_valid writes the timeout in ticks; cfg_ready is always high. Write
//   it only while no command is in flight.
// Path: front register, command queue, then the engine's output register.
// Throughput: one command per cycle when the reply is a single beat and no
//   result is stalled. A release that hands the lock to a waiter passes a
//   grant state (waiter FIFO memory read), an unlock then a reply state.
// Reset: lock free, waiter FIFO empty, timeout 60 ticks.
// Stall: a stalled result holds its beat; the front register and a two-entry
//   command queue keep taking input until both are full, then in_stall rises.
// ----------------------------------------------------------------------------
module queued_lock_arbiter_with_timeout import qla_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [TICKS_W-1:0]  cfg_timeout_ticks,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_command,
  input  logic [ADDR_W-1:0]   in_client_addr,
  input  logic [PORT_W-1:0]   in_client_port,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [ADDR_W-1:0]   out_reply_addr,
  output logic [PORT_W-1:0]   out_dest_port,
  output logic [2:0]          out_response,
  output logic                out_last
);

  logic         push;
  item_t        push_item;
  logic         pop;
  cmdq_status_t q_status;

  assign cfg_ready = 1'b1;

  qla_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_client_addr (in_client_addr),
    .in_client_port (in_client_port),
    .q_full         (q_status.full),
    .push           (push),
    .push_item      (push_item)
  );

  qla_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .status    (q_status)
  );

  qla_engine #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_timeout_ticks (cfg_timeout_ticks),
    .q_status          (q_status),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_reply_addr    (out_reply_addr),
    .out_dest_port     (out_dest_port),
    .out_response      (out_response),
    .out_last          (out_last)
  );

endmodule

[tb/sv/qla_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qla_checker
// Tracks the lock, its waiters and the inactivity timer from the accepted
// command beats and compares each reply beat with the oldest predicted reply.
// ----------------------------------------------------------------------------
module qla_checker import qla_pkg::*; #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [TICKS_W-1:0] cfg_timeout_ticks,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [ADDR_W-1:0]  in_client_addr,
  input  logic [PORT_W-1:0]  in_client_port,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [ADDR_W-1:0]  out_reply_addr,
  input  logic [PORT_W-1:0]  out_dest_port,
  input  logic [2:0]         out_response,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending,
  output int                 cmds_seen,
  output int                 replies_seen,
  output logic [6:0]         rsp_seen
);

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
  } client_t;

  typedef struct {
    client_t dest;
    rsp_t    rsp;
    logic    last;
  } reply_t;

  reply_t             replies_due[$];
  client_t            waiters[$];
  logic               lock_busy;
  client_t            owner;
  logic [TICKS_W-1:0] timeout_cfg;
  logic [TICKS_W-1:0] inactivity;

  function automatic void add_reply(client_t dest, rsp_t rsp, logic last);
    reply_t r;
    r.dest = dest;
    r.rsp = rsp;
    r.last = last;
    replies_due.push_back(r);
  endfunction

  function automatic void grant(client_t who);
    lock_busy = 1'b1;
    owner = who;
    inactivity = timeout_cfg;
  endfunction

  // frees the lock; true when the head waiter took it over
  function automatic bit hand_on();
    lock_busy = 1'b0;
    if (waiters.size() == 0) return 1'b0;
    grant(waiters.pop_front());
    return 1'b1;
  endfunction

  function automatic void predict_replies(cmd_t cmd, client_t who);
    bit is_owner;
    is_owner = lock_busy && (owner == who);
    case (cmd)
      CMD_LOCK: begin
        if (!lock_busy) begin
          grant(who);
          add_reply(who, RSP_LOCK_OK, 1'b1);
        end else if (is_owner) begin
          add_reply(who, RSP_ALREADY, 1'b1);
        end else if (waiters.size() < QUEUE_DEPTH) begin
          waiters.push_back(who);
          add_reply(who, RSP_WAIT, 1'b1);
        end else begin
          add_reply(who, RSP_FULL, 1'b1);
        end
      end
      CMD_EDIT: begin
        if (is_owner) begin
          inactivity = timeout_cfg;
          add_reply(who, RSP_EDIT_OK, 1'b1);
        end else begin
          add_reply(who, RSP_NO_LOCK, 1'b1);
        end
      end
      CMD_UNLOCK: begin
        if (hand_on()) add_reply(owner, RSP_LOCK_OK, 1'b0);
        add_reply(who, RSP_UNLOCKED, 1'b1);
      end
      default: begin
        if (lock_busy) begin
          if (inactivity <= 1) begin
            inactivity = '0;
            if (hand_on()) add_reply(owner, RSP_LOCK_OK, 1'b1);
          end else begin
            inactivity = inactivity - 1'b1;
          end
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    reply_t  exp_r;
    client_t who;
    if (!rst_n) begin
      lock_busy = 1'b0;
      owner = '0;
      inactivity = '0;
      timeout_cfg = TIMEOUT_RESET;
      waiters.delete();
      replies_due.delete();
      fail_count = 0;
      cmds_seen = 0;
      replies_seen = 0;
      rsp_seen = '0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (out_response < 3'd7) rsp_seen[out_response] = 1'b1;
        if (replies_due.size() == 0) begin
          $error("unexpected reply beat: dest %h:%h response %0d last %0b",
                 out_reply_addr, out_dest_port, out_response, out_last);
          fail_count++;
        end else begin
          exp_r = replies_due.pop_front();
          if (out_reply_addr !== exp_r.dest.addr) begin
            $error("reply_addr: expected %h, actual %h", exp_r.dest.addr, out_reply_addr);
            fail_count++;
          end
          if (out_dest_port !== exp_r.dest.port) begin
            $error("dest_port: expected %h, actual %h", exp_r.dest.port, out_dest_port);
            fail_count++;
          end
          if (out_response !== exp_r.rsp) begin
            $error("response: expected %0d (%s), actual %0d",
                   exp_r.rsp, exp_r.rsp.name(), out_response);
            fail_count++;
          end
          if (out_last !== exp_r.last) begin
            $error("last: expected %0b, actual %0b", exp_r.last, out_last);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) timeout_cfg = cfg_timeout_ticks;
      if (in_valid && !in_stall) begin
        cmds_seen++;
        who.addr = in_client_addr;
        who.port = in_client_port;
        predict_replies(cmd_t'(in_command), who);
      end
    end
    pending = replies_due.size();
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives lock, edit, unlock and tick beats into the queued lock arbiter under
// several timeout settings and idle patterns; qla_checker predicts and checks.
// ----------------------------------------------------------------------------
module testbench;
  import qla_pkg::*;

  localparam int WAIT_DEPTH = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_N = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int N_PHASES = 6;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [TICKS_W-1:0] cfg_timeout_ticks = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_command = CMD_TICK;
  logic [ADDR_W-1:0]  in_client_addr = '0;
  logic [PORT_W-1:0]  in_client_port = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [ADDR_W-1:0]  out_reply_addr;
  logic [PORT_W-1:0]  out_dest_port;
  logic [2:0]         out_response;
  logic               out_last;

  int          fail_count;
  int          pending;
  int          cmds_seen;
  int          replies_seen;
  logic [6:0]  rsp_seen;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          hold_gen = 0;
  int          hold_seen = 0;
  int          hold_left = 0;

  logic [ADDR_W-1:0]  pool_addr[POOL_N];
  logic [PORT_W-1:0]  pool_port[POOL_N];
  int unsigned        phase_ticks[N_PHASES] = '{1, 3, 65535, 0, 5, 60};
  int                 phase_send[N_PHASES] = '{24, 24, 49, 49, 0, 0};
  int                 phase_recv[N_PHASES] = '{49, 49, 24, 24, 0, 0};
  int                 phase_len[N_PHASES] = '{150, 150, 150, 100, 150, 150};

  always #1 clk = ~clk;

  queued_lock_arbiter_with_timeout #(.QUEUE_DEPTH(WAIT_DEPTH)) DUT (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_timeout_ticks,
    .in_valid, .in_stall, .in_command, .in_client_addr, .in_client_port,
    .out_valid, .out_stall, .out_reply_addr, .out_dest_port, .out_response, .out_last
  );

  qla_checker #(.QUEUE_DEPTH(WAIT_DEPTH)) u_checker (
    .clk, .rst_n,
    .cfg_valid, .cfg_ready, .cfg_timeout_ticks,
    .in_valid, .in_stall, .in_command, .in_client_addr, .in_client_port,
    .out_valid, .out_stall, .out_reply_addr, .out_dest_port, .out_response, .out_last,
    .fail_count, .pending, .cmds_seen, .replies_seen, .rsp_seen
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("queued_lock_arbiter_with_timeout verification failed");
      $finish;
    end
  end

  // reply side: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_gen) begin
      hold_left = HOLD_CYCLES;
      hold_seen = hold_gen;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_beat(cmd_t cmd, logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_client_addr <= addr;
    in_client_port <= port;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_timeout(logic [TICKS_W-1:0] ticks);
    cfg_valid <= 1'b1;
    cfg_timeout_ticks <= ticks;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_beat();
    int                k;
    int                roll;
    cmd_t              cmd;
    logic [ADDR_W-1:0] addr;
    logic [PORT_W-1:0] port;
    k = $urandom_range(POOL_N - 1);
    addr = pool_addr[k];
    port = pool_port[k];
    if ($urandom_range(9) == 0) begin
      addr = $urandom;
      port = PORT_W'($urandom);
    end
    roll = $urandom_range(99);
    if (roll < 35) cmd = CMD_LOCK;
    else if (roll < 60) cmd = CMD_EDIT;
    else if (roll < 75) cmd = CMD_UNLOCK;
    else begin
      cmd = CMD_TICK;
      addr = $urandom;
      port = PORT_W'($urandom);
    end
    send_beat(cmd, addr, port);
  endtask

  initial begin
    for (int i = 0; i < POOL_N; i++) begin
      pool_addr[i] = $urandom;
      pool_port[i] = PORT_W'($urandom);
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed pass, timeout of two ticks
    write_timeout(16'd2);
    send_beat(CMD_TICK, '0, '0);
    send_beat(CMD_UNLOCK, 32'h8000_0001, 16'h8001);
    send_beat(CMD_EDIT, 32'h8000_0001, 16'h8001);
    send_beat(CMD_LOCK, '0, '0);
    send_beat(CMD_LOCK, '0, '0);
    send_beat(CMD_EDIT, '0, '0);
    send_beat(CMD_EDIT, '1, '1);
    send_beat(CMD_LOCK, '1, '1);
    send_beat(CMD_LOCK, '1, '1);
    for (int i = 0; i < 6; i++)
      send_beat(CMD_LOCK, {8'(i + 1), 24'hA5A5A5}, 16'h0F0F ^ PORT_W'(i));
    send_beat(CMD_LOCK, 32'h8000_0001, 16'h8001);
    send_beat(CMD_TICK, 32'h5555_5555, 16'hAAAA);
    send_beat(CMD_TICK, 32'hAAAA_AAAA, 16'h5555);
    send_beat(CMD_UNLOCK, 32'h8000_0001, 16'h8001);
    send_beat(CMD_LOCK, '1, '1);
    send_beat(CMD_UNLOCK, '1, '1);
    drain_replies();

    // reply side holds off while commands keep coming
    hold_gen++;
    for (int i = 0; i < 60; i++) send_random_beat();
    drain_replies();

    for (int p = 0; p < N_PHASES; p++) begin
      write_timeout(TICKS_W'(phase_ticks[p]));
      send_idle = phase_send[p];
      recv_idle = phase_recv[p];
      for (int i = 0; i < phase_len[p]; i++) send_random_beat();
      drain_replies();
    end

    $display("Sent %0d commands, checked %0d replies; timeouts 2, 0, 1, 3, 5, 60, 65535.",
             cmds_seen, replies_seen);
    $display("Reply codes seen (bit per code, lock_ok lowest): %b", rsp_seen);
    if (fail_count == 0) begin
      $display("queued_lock_arbiter_with_timeout verification clean");
    end else begin
      $display("queued_lock_arbiter_with_timeout verification failed");
    end
    $finish;
  end

endmodule
